// File: hw/rtl/kfd_pkg.sv
// KISS frame decoder package: framing codes, event codes, widths and the
// result struct shared by the decode stage, the output stage and the top level.
package kfd_pkg;

    localparam int BUFFER_BYTES = 512;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int LEN_W        = 9;
    localparam int LEN_MAX      = (1 << LEN_W) - 1;
    localparam int CMP_W        = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int EV_W         = 3;

    localparam logic [7:0] CODE_FEND  = 8'hC0;
    localparam logic [7:0] CODE_FESC  = 8'hDB;
    localparam logic [7:0] CODE_TFEND = 8'hDC;
    localparam logic [7:0] CODE_TFESC = 8'hDD;
    localparam logic [7:0] CODE_EXIT  = 8'h1B;
    localparam logic [7:0] CMD_PAYLOAD = 8'h00;
    localparam logic [7:0] CMD_LEAVE  = 8'hFF;

    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 3'd0,
        EV_BYTE    = 3'd1,
        EV_DONE    = 3'd2,
        EV_DISCARD = 3'd3,
        EV_EXIT    = 3'd4,
        EV_IGNORED = 3'd5
    } t_event;

    typedef struct packed {
        t_event             kind;
        logic [7:0]         pbyte;
        logic [LEN_W-1:0]   flen;
    } t_result;

endpackage

// File: hw/rtl/kfd_decode.sv
// KISS frame decoder: deframing state and the single-pass decode of one byte.
// Depends on kfd_pkg.
module kfd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output kfd_pkg::t_result  o_result
);
    import kfd_pkg::*;

    logic               r_in_frame, n_in_frame;
    logic               r_esc, n_esc;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_cmd, n_cmd;

    logic               store;
    logic [7:0]         dec;
    logic [CNT_W-1:0]   plen;
    logic [CMP_W-1:0]   plen_ext;
    t_result            res;

    always_comb begin
        n_in_frame = r_in_frame;
        n_esc      = r_esc;
        n_count    = r_count;
        n_cmd      = r_cmd;
        store      = 1'b0;
        dec        = i_byte;
        plen       = r_count - CNT_W'(1);
        plen_ext   = CMP_W'(plen);
        res.kind   = EV_NONE;
        res.pbyte  = 8'd0;
        res.flen   = '0;

        if (i_byte == CODE_EXIT) begin
            n_in_frame = 1'b0;
            n_esc      = 1'b0;
            n_count    = '0;
            res.kind   = EV_EXIT;
        end else if (i_byte == CODE_FEND) begin
            if (r_in_frame && (r_count != '0)) begin
                if (r_cmd == CMD_LEAVE) begin
                    res.kind = EV_EXIT;
                end else if ((r_cmd == CMD_PAYLOAD) && (plen != '0)) begin
                    res.kind = EV_DONE;
                    res.flen = (plen_ext > CMP_W'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                            : LEN_W'(plen_ext);
                end else begin
                    res.kind = EV_IGNORED;
                end
            end
            n_in_frame = 1'b1;
            n_esc      = 1'b0;
            n_count    = '0;
        end else if (r_in_frame) begin
            store = 1'b1;
            if (r_esc) begin
                n_esc = 1'b0;
                if (i_byte == CODE_TFEND) begin
                    dec = CODE_FEND;
                end else if (i_byte == CODE_TFESC) begin
                    dec = CODE_FESC;
                end else begin
                    n_in_frame = 1'b0;
                    n_count    = '0;
                    res.kind   = EV_DISCARD;
                    store      = 1'b0;
                end
            end else if (i_byte == CODE_FESC) begin
                n_esc = 1'b1;
                store = 1'b0;
            end
        end

        if (store) begin
            if (r_count < CNT_W'(BUFFER_BYTES)) begin
                if (r_count == '0) begin
                    n_cmd = dec;
                end else if (r_cmd == CMD_PAYLOAD) begin
                    res.kind  = EV_BYTE;
                    res.pbyte = dec;
                end
                n_count = r_count + CNT_W'(1);
            end else begin
                n_in_frame = 1'b0;
                n_esc      = 1'b0;
                n_count    = '0;
                res.kind   = EV_DISCARD;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
            r_count    <= '0;
            r_cmd      <= 8'd0;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
            r_count    <= n_count;
            r_cmd      <= n_cmd;
        end
    end

endmodule

// File: hw/rtl/kfd_out_stage.sv
// KISS frame decoder: result register with valid/ready toward the sink.
// Depends on kfd_pkg.
module kfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  kfd_pkg::t_result  i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output kfd_pkg::t_result  o_result
);
    import kfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hw/rtl/kiss_frame_decoder_core.sv
// KISS frame decoder top level: input register, decode stage, result register.
// Depends on kfd_pkg, kfd_decode and kfd_out_stage.
//
// Takes one serial byte per item and gives exactly one event item per byte
// (event_kind 0 when nothing happens). Throughput is one byte per clock
// while the sink is ready; an accepted byte is loaded into the input
// register and then, through the single decode stage, into the result
// register, where it is valid. Frame state advances only when a byte moves
// from the input register into the result register, so stalls on the
// output side simply hold the pipe.
module kiss_frame_decoder_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rx_valid,
    output logic                     o_rx_ready,
    input  logic [7:0]               i_rx_byte,
    output logic                     o_ev_valid,
    input  logic                     i_ev_ready,
    output logic [kfd_pkg::EV_W-1:0] o_event_kind,
    output logic [7:0]               o_payload_byte,
    output logic [kfd_pkg::LEN_W-1:0] o_frame_length
);
    import kfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       step;
    t_result    dec_result;
    t_result    out_result;

    assign step       = r_in_valid && out_free;
    assign o_rx_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    kfd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (dec_result)
    );

    kfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_in_valid),
        .i_result (dec_result),
        .i_ready  (i_ev_ready),
        .o_free   (out_free),
        .o_valid  (o_ev_valid),
        .o_result (out_result)
    );

    assign o_event_kind   = out_result.kind;
    assign o_payload_byte = out_result.pbyte;
    assign o_frame_length = out_result.flen;

endmodule

// File: hw/rtl/kfd_checker.sv
// KISS frame decoder port checker and its bind to the top level.
// Depends on kfd_pkg and kiss_frame_decoder_core.
module kfd_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_ev_valid,
    input  logic                      i_ev_ready,
    input  logic [kfd_pkg::EV_W-1:0]  o_event_kind,
    input  logic [7:0]                o_payload_byte,
    input  logic [kfd_pkg::LEN_W-1:0] o_frame_length
);
    import kfd_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ev_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && !i_ev_ready) |=>
            (o_ev_valid && $stable(o_event_kind) && $stable(o_payload_byte)
             && $stable(o_frame_length)))
        else $error("stalled item changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid |-> (o_event_kind <= EV_W'(EV_IGNORED)))
        else $error("event code out of range");

    a_byte_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && (o_event_kind != EV_W'(EV_BYTE))) |-> (o_payload_byte == 8'd0))
        else $error("payload byte set on non-byte event");

    a_len_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid |-> ((o_event_kind == EV_W'(EV_DONE)) == (o_frame_length != '0)))
        else $error("frame length inconsistent with event");

endmodule

bind kiss_frame_decoder_core kfd_checker u_kfd_checker (.*);
